FILE: rtl/core/assert_macros.svh
// assertion macros shared by the core rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define BRB_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// expression must never be true outside reset
`define BRB_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define BRB_ASSERT(label, clk, rst, prop)
`define BRB_ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

FILE: rtl/core/brb_pkg.sv
// shared widths, codes and types of the byte ring buffer core
package brb_pkg;

   // payload field widths
   localparam int ACTION_W    = 3;
   localparam int DATA_W      = 8;
   localparam int LEN_W       = 11;
   localparam int POS_W       = 10;
   localparam int STATUS_W    = 2;
   localparam int RING_SIZE_W = 11;

   // ring geometry
   localparam int DEPTH_DEFAULT   = 1024;
   localparam int RING_SIZE_RESET = 1024;
   localparam int RING_SIZE_MAX   = (1 << RING_SIZE_W) - 1;

   // fetch offset reduction: quotient of position by depth (depth is at least 4)
   localparam int QUOT_W      = POS_W - 2;
   localparam int RECIP_SHIFT = POS_W + 1;

   // request action codes
   localparam logic [ACTION_W-1:0] ACT_STORE    = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_SNAPSHOT = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_FETCH    = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_RELEASE  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_CLOSE    = 3'd4;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] ST_CLOSED   = 2'd2;

   // internal operation codes after classification
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_NONE     = 3'd0;
   localparam logic [OP_W-1:0] OP_STORE    = 3'd1;
   localparam logic [OP_W-1:0] OP_SNAPSHOT = 3'd2;
   localparam logic [OP_W-1:0] OP_FETCH    = 3'd3;
   localparam logic [OP_W-1:0] OP_RELEASE  = 3'd4;
   localparam logic [OP_W-1:0] OP_CLOSE    = 3'd5;

   // one classified request waiting for the back end
   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [DATA_W-1:0] data_byte;
      logic [LEN_W-1:0]  message_length;
      logic              last_of_message;
      logic [POS_W-1:0]  position;
      logic [QUOT_W-1:0] fetch_quot;
   } q_entry_type;

endpackage

FILE: rtl/core/brb_if.sv
// request and response channel interfaces of the byte ring buffer core
interface brb_req_if import brb_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [DATA_W-1:0]   data_byte;
   logic [LEN_W-1:0]    message_length;
   logic                last_of_message;
   logic [POS_W-1:0]    position;

   modport source (
      output valid, action, data_byte, message_length, last_of_message, position,
      input  ready
   );
   modport sink (
      input  valid, action, data_byte, message_length, last_of_message, position,
      output ready
   );
endinterface

interface brb_rsp_if import brb_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [DATA_W-1:0]   fetched_byte;
   logic [POS_W-1:0]    first_start;
   logic [LEN_W-1:0]    first_length;
   logic [POS_W-1:0]    second_length;
   logic [POS_W-1:0]    mark;
   logic [POS_W-1:0]    used_count;

   modport source (
      output valid, status, fetched_byte, first_start, first_length, second_length,
             mark, used_count,
      input  ready
   );
   modport sink (
      input  valid, status, fetched_byte, first_start, first_length, second_length,
             mark, used_count,
      output ready
   );
endinterface

FILE: rtl/core/brb_front.sv
// request classification and fetch offset quotient
module brb_front import brb_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   brb_req_if.sink     req_chan,
   output logic        ent_valid,
   input  logic        ent_ready,
   output q_entry_type ent
);

   localparam int RECIP = (1 << RECIP_SHIFT) / DEPTH;

   logic [2*POS_W-1:0] quot_prod;

   assign ent_valid      = req_chan.valid;
   assign req_chan.ready = ent_ready;

   always_comb begin
      // estimate of position / depth, low by at most one
      quot_prod = (2*POS_W)'(req_chan.position) * (2*POS_W)'(RECIP);

      ent.data_byte       = req_chan.data_byte;
      ent.message_length  = req_chan.message_length;
      ent.last_of_message = req_chan.last_of_message;
      ent.position        = req_chan.position;
      ent.fetch_quot      = QUOT_W'(quot_prod >> RECIP_SHIFT);

      unique case (req_chan.action)
         ACT_STORE:    ent.op = OP_STORE;
         ACT_SNAPSHOT: ent.op = OP_SNAPSHOT;
         ACT_FETCH:    ent.op = OP_FETCH;
         ACT_RELEASE:  ent.op = OP_RELEASE;
         ACT_CLOSE:    ent.op = OP_CLOSE;
         default:      ent.op = OP_NONE;
      endcase
   end

endmodule

FILE: rtl/core/brb_queue.sv
// two entry queue between front and back end
module brb_queue import brb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  q_entry_type in_ent,
   output logic        out_valid,
   input  logic        out_ready,
   output q_entry_type out_ent
);

   localparam int QDEPTH = 2;
   localparam int IDX_W  = $clog2(QDEPTH);
   localparam int CNT_W  = $clog2(QDEPTH + 1);

   q_entry_type            slot_ff [QDEPTH];
   logic [IDX_W-1:0]       wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]       rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   push, pop;

   assign in_ready  = (count_ff != CNT_W'(QDEPTH));
   assign out_valid = (count_ff != '0);
   assign out_ent   = slot_ff[rd_idx_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      count_in  = count_ff;
      if (push) begin
         wr_idx_in = (wr_idx_ff == IDX_W'(QDEPTH - 1)) ? '0 : wr_idx_ff + IDX_W'(1);
      end
      if (pop) begin
         rd_idx_in = (rd_idx_ff == IDX_W'(QDEPTH - 1)) ? '0 : rd_idx_ff + IDX_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_idx_ff] <= in_ent;
      end
   end

endmodule

FILE: rtl/core/brb_back.sv
// ring state, byte memory and response register
module brb_back import brb_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [RING_SIZE_W-1:0] csr_wdata,
   input  logic                   ent_valid,
   output logic                   ent_pop,
   input  q_entry_type            ent,
   brb_rsp_if.source              rsp_chan
);

   localparam int SIZE_MAX   = (DEPTH < RING_SIZE_MAX) ? DEPTH : RING_SIZE_MAX;
   localparam int SW         = $clog2(SIZE_MAX + 1);
   localparam int PW         = $clog2(SIZE_MAX);
   localparam int AW         = $clog2(DEPTH);
   localparam int SIZE_RESET = (RING_SIZE_RESET > SIZE_MAX) ? SIZE_MAX : RING_SIZE_RESET;
   localparam logic [POS_W:0] DEPTH_LOW = (POS_W+1)'(DEPTH);

   function automatic logic [SW-1:0] used_of(input logic [PW-1:0] w,
                                             input logic [PW-1:0] r,
                                             input logic [SW-1:0] s);
      logic [SW-1:0] d;
      d = SW'(w) - SW'(r);
      if (r > w) begin
         d = d + s;
      end
      return d;
   endfunction

   logic [DATA_W-1:0]   mem [DEPTH];

   logic [SW-1:0]       size_ff, csr_size;
   logic [PW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic                closed_ff, closed_in;
   logic                inside_ff, inside_in;
   logic [STATUS_W-1:0] msg_status_ff, msg_status_in;
   logic [PW-1:0]       left_ff, left_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                fetch_sel_ff, fetch_sel_in;
   logic [POS_W-1:0]    first_start_ff, first_start_in;
   logic [LEN_W-1:0]    first_len_ff, first_len_in;
   logic [POS_W-1:0]    second_len_ff, second_len_in;
   logic [POS_W-1:0]    mark_ff, mark_in;
   logic [POS_W-1:0]    used_ff, used_in;
   logic [DATA_W-1:0]   rd_data_ff;

   logic [SW-1:0]       used_cur, free_sp, wr_inc, used_new;
   logic [PW-1:0]       wr_adv, left_cur;
   logic [STATUS_W-1:0] first_st, msg_st;
   logic                do_write, mem_we, mem_re;
   logic [POS_W:0]      quot_depth, rem_raw, rem;
   logic [AW-1:0]       raddr;

   assign ent_pop = ent_valid && (!rsp_valid_ff || rsp_chan.ready);

   // clamp of the written ring size to 2..SIZE_MAX
   always_comb begin
      if (csr_wdata < RING_SIZE_W'(2)) begin
         csr_size = SW'(2);
      end else if (csr_wdata > RING_SIZE_W'(SIZE_MAX)) begin
         csr_size = SW'(SIZE_MAX);
      end else begin
         csr_size = SW'(csr_wdata);
      end
   end

   always_comb begin
      used_cur = used_of(wr_ptr_ff, rd_ptr_ff, size_ff);
      free_sp  = size_ff - used_cur;
      wr_inc   = SW'(wr_ptr_ff) + SW'(1);
      wr_adv   = (wr_inc >= size_ff) ? '0 : PW'(wr_inc);

      // admission check made on the first byte of a message
      if (closed_ff) begin
         first_st = ST_CLOSED;
      end else if (ent.message_length >= size_ff || ent.message_length >= free_sp) begin
         first_st = ST_OVERFLOW;
      end else begin
         first_st = ST_OK;
      end
      msg_st   = inside_ff ? msg_status_ff : first_st;
      left_cur = inside_ff ? left_ff : ((first_st == ST_OK) ? PW'(ent.message_length) : '0);
      if (closed_ff) begin
         msg_st   = ST_CLOSED;
         left_cur = '0;
      end
      do_write = (msg_st == ST_OK) && (left_cur != '0);

      // position mod depth, quotient estimate corrected once
      quot_depth = (POS_W+1)'(ent.fetch_quot) * DEPTH_LOW;
      rem_raw    = {1'b0, ent.position} - quot_depth;
      rem        = (32'(rem_raw) >= DEPTH) ? rem_raw - DEPTH_LOW : rem_raw;
      raddr      = AW'(rem);

      wr_ptr_in      = wr_ptr_ff;
      rd_ptr_in      = rd_ptr_ff;
      closed_in      = closed_ff;
      inside_in      = inside_ff;
      msg_status_in  = msg_status_ff;
      left_in        = left_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      rsp_status_in  = ST_OK;
      fetch_sel_in   = 1'b0;
      first_start_in = '0;
      first_len_in   = '0;
      second_len_in  = '0;
      mark_in        = '0;

      unique case (ent.op)
         OP_STORE: begin
            msg_status_in = msg_st;
            rsp_status_in = msg_st;
            if (do_write) begin
               mem_we    = ent_pop;
               wr_ptr_in = wr_adv;
               left_in   = left_cur - PW'(1);
            end else begin
               left_in = left_cur;
            end
            if (ent.last_of_message) begin
               inside_in = 1'b0;
               left_in   = '0;
            end else begin
               inside_in = 1'b1;
            end
         end
         OP_SNAPSHOT: begin
            if (closed_ff) begin
               rsp_status_in = ST_CLOSED;
            end else begin
               first_start_in = POS_W'(rd_ptr_ff);
               mark_in        = POS_W'(wr_ptr_ff);
               if (rd_ptr_ff <= wr_ptr_ff) begin
                  first_len_in = LEN_W'(SW'(wr_ptr_ff) - SW'(rd_ptr_ff));
               end else begin
                  first_len_in  = LEN_W'(size_ff - SW'(rd_ptr_ff));
                  second_len_in = POS_W'(wr_ptr_ff);
               end
            end
         end
         OP_FETCH: begin
            if (closed_ff) begin
               rsp_status_in = ST_CLOSED;
            end else begin
               fetch_sel_in = 1'b1;
               mem_re       = ent_pop;
            end
         end
         OP_RELEASE: begin
            if (closed_ff) begin
               rsp_status_in = ST_CLOSED;
            end else if (ent.position >= size_ff) begin
               rsp_status_in = ST_OVERFLOW;
            end else begin
               rd_ptr_in = PW'(ent.position);
            end
         end
         OP_CLOSE: begin
            closed_in = 1'b1;
         end
         default: begin
         end
      endcase

      used_new     = used_of(wr_ptr_in, rd_ptr_in, size_ff);
      used_in      = POS_W'(used_new);
      rsp_valid_in = ent_pop || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff       <= SW'(SIZE_RESET);
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         closed_ff     <= 1'b0;
         inside_ff     <= 1'b0;
         msg_status_ff <= ST_OK;
         left_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            size_ff       <= csr_size;
            wr_ptr_ff     <= '0;
            rd_ptr_ff     <= '0;
            inside_ff     <= 1'b0;
            msg_status_ff <= ST_OK;
            left_ff       <= '0;
         end else if (ent_pop) begin
            wr_ptr_ff     <= wr_ptr_in;
            rd_ptr_ff     <= rd_ptr_in;
            closed_ff     <= closed_in;
            inside_ff     <= inside_in;
            msg_status_ff <= msg_status_in;
            left_ff       <= left_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ent_pop) begin
         rsp_status_ff  <= rsp_status_in;
         fetch_sel_ff   <= fetch_sel_in;
         first_start_ff <= first_start_in;
         first_len_ff   <= first_len_in;
         second_len_ff  <= second_len_in;
         mark_ff        <= mark_in;
         used_ff        <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[AW'(wr_ptr_ff)] <= ent.data_byte;
      end
      if (mem_re) begin
         rd_data_ff <= mem[raddr];
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.fetched_byte  = fetch_sel_ff ? rd_data_ff : '0;
   assign rsp_chan.first_start   = first_start_ff;
   assign rsp_chan.first_length  = first_len_ff;
   assign rsp_chan.second_length = second_len_ff;
   assign rsp_chan.mark          = mark_ff;
   assign rsp_chan.used_count    = used_ff;

endmodule

FILE: rtl/core/byte_ring_buffer_with_span_read_core.sv
// top level of the byte ring buffer with span read
// Byte ring buffer with span read. Requests arrive on req_chan (store a
// message byte, snapshot the readable spans, fetch a byte, release the read
// position to a mark, close); each request gives exactly one transfer on
// rsp_chan, in order. A store decides at the first byte of a message whether
// the whole message fits: it is refused when closed, and overflows when its
// length is at least the ring size or at least the free space; one slot
// always stays empty. The ring size comes from csr_wdata on csr_we, is clamped
// to 2..DEPTH and clears the pointers and any message in progress (the closed
// flag stays); write it only while no request is in flight. Throughput is one
// request per clock while rsp_chan is not stalled, set by the single port byte
// memory in the back end that each request touches at most once; a response
// is registered in the back end after its request has passed the queue, and
// it transfers when rsp_chan is not stalled. A two entry queue sits between
// the classifying front end and the back end; while a response waits in the
// response register the back end holds, and the queue takes up to two more
// requests before req_chan.ready drops.
// There is no clearing pass after reset: a fetch of a slot never written
// returns an arbitrary byte.
module byte_ring_buffer_with_span_read_core import brb_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [RING_SIZE_W-1:0] csr_wdata,
   brb_req_if.sink                req_chan,
   brb_rsp_if.source              rsp_chan
);

`include "assert_macros.svh"

   // front to queue
   q_entry_type front_ent;
   logic        front_valid;
   logic        front_ready;

   // queue to back end
   q_entry_type q_ent;
   logic        q_valid;
   logic        q_pop;

   // closed response and its empty payload
   logic        rsp_closed;
   logic        rsp_closed_clean;

   // classify requests and precompute the fetch offset quotient
   brb_front #(
      .DEPTH (DEPTH)
   ) u_front (
      .req_chan  (req_chan),
      .ent_valid (front_valid),
      .ent_ready (front_ready),
      .ent       (front_ent)
   );

   // decouples request acceptance from the back end
   brb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_ent    (front_ent),
      .out_valid (q_valid),
      .out_ready (q_pop),
      .out_ent   (q_ent)
   );

   // ring pointers, message admission, byte memory and response register
   brb_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .ent_valid (q_valid),
      .ent_pop   (q_pop),
      .ent       (q_ent),
      .rsp_chan  (rsp_chan)
   );

   assign rsp_closed       = rsp_chan.valid && (rsp_chan.status == ST_CLOSED);
   assign rsp_closed_clean = (rsp_chan.fetched_byte == '0) && (rsp_chan.mark == '0) &&
                             (rsp_chan.first_length == '0);

   // every request taken by the back end shows up as a response next cycle
   `BRB_ASSERT(a_pop_gives_rsp, clock, reset, q_pop |=> rsp_chan.valid)

   // a stalled response is never overwritten by the next request
   `BRB_ASSERT_NEVER(a_no_overwrite, clock, reset, rsp_chan.valid && !rsp_chan.ready && q_pop)

   // a closed response carries no byte, span or mark
   `BRB_ASSERT(a_closed_fields_zero, clock, reset, rsp_closed |-> rsp_closed_clean)

endmodule
